// ===== sv/ck24_pkg.sv =====
// Package for the 24-hour clock with button time setting.
// Holds transaction structs, the mode phase enum, state struct and digit step functions.
// No dependencies.
package ck24_pkg;

	localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [0:0] REG_LONG_PRESS = 1'b0;

	typedef enum logic [1:0] {
		PH_RUN        = 2'd0,
		PH_ENTER_WAIT = 2'd1,
		PH_SETTING    = 2'd2,
		PH_EXIT_WAIT  = 2'd3
	} phase_t;

	typedef struct packed {
		logic left_button;
		logic right_button;
	} ck24_in_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic       setting_mode;
		logic [2:0] selected_digit;
	} ck24_out_t;

	// history bit 0 = current level, bit 1 = previous level
	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		phase_t     phase;
		logic [2:0] digit;
		logic [1:0] hist_l;
		logic [1:0] hist_r;
	} ck24_state_t;

	function automatic logic [3:0] mod10(input logic [5:0] v);
		logic [5:0] r;
		begin
			if (v >= 6'd60) r = v - 6'd60;
			else if (v >= 6'd50) r = v - 6'd50;
			else if (v >= 6'd40) r = v - 6'd40;
			else if (v >= 6'd30) r = v - 6'd30;
			else if (v >= 6'd20) r = v - 6'd20;
			else if (v >= 6'd10) r = v - 6'd10;
			else r = v;
			return r[3:0];
		end
	endfunction

	function automatic logic [5:0] tens_step(input logic [5:0] v);
		return (v >= 6'd50) ? v - 6'd50 : v + 6'd10;
	endfunction

	function automatic logic [5:0] units_step(input logic [5:0] v);
		return (mod10(v) == 4'd9) ? v - 6'd9 : v + 6'd1;
	endfunction

	function automatic logic [4:0] hour_tens_step(input logic [4:0] h);
		logic [4:0] r;
		begin
			if (h >= 5'd20) r = h - 5'd20;
			else if (h >= 5'd10 && mod10({1'b0, h}) >= 4'd4) r = h - 5'd10;
			else r = h + 5'd10;
			return r;
		end
	endfunction

	function automatic logic [4:0] hour_units_step(input logic [4:0] h);
		logic [5:0] u;
		begin
			u = units_step({1'b0, h});
			if (h == 5'd23) return 5'd20;
			else if (h >= 5'd20) return h + 5'd1;
			else return u[4:0];
		end
	endfunction

endpackage

// ===== sv/ck24_cfg.sv =====
// APB-style configuration register bank for the 24-hour clock.
// Holds the long-press threshold. Depends on ck24_pkg.
module ck24_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ck24_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ck24_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ck24_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [15:0]                     long_press_ticks
);
	import ck24_pkg::*;

	logic [15:0] lpt_q;
	logic        hit;

	assign pready = 1'b1;
	assign hit = (paddr[2] == REG_LONG_PRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpt_q <= LONG_PRESS_RESET;
		end else if (psel && penable && pwrite && hit) begin
			lpt_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(CFG_DATA_W-16){1'b0}}, lpt_q};
		end
	end

	assign long_press_ticks = lpt_q;

endmodule

// ===== sv/ck24_core.sv =====
// Next-state logic of the 24-hour clock for one tick transaction.
// Button timers, mode phase, time advance and digit stepping. Depends on ck24_pkg.
module ck24_core #(
	parameter int unsigned TICKS_PER_SECOND = 1000,
	parameter int unsigned PRESS_TIMER_BITS = 16,
	parameter int unsigned MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1
) (
	input  ck24_pkg::ck24_in_t      item,
	input  ck24_pkg::ck24_state_t   st,
	input  logic [MS_W-1:0]         millis,
	input  logic [PRESS_TIMER_BITS-1:0] timer_l,
	input  logic [PRESS_TIMER_BITS-1:0] timer_r,
	input  logic [15:0]             long_press_ticks,
	output ck24_pkg::ck24_state_t   st_n,
	output logic [MS_W-1:0]         millis_n,
	output logic [PRESS_TIMER_BITS-1:0] timer_l_n,
	output logic [PRESS_TIMER_BITS-1:0] timer_r_n,
	output ck24_pkg::ck24_out_t     res
);
	import ck24_pkg::*;

	localparam int unsigned CMP_W = (PRESS_TIMER_BITS > 16) ? PRESS_TIMER_BITS : 16;
	localparam logic [MS_W-1:0] MS_LAST = MS_W'(TICKS_PER_SECOND - 1);

	logic       lvl_l, lvl_r;
	logic       short_l, short_r, long_r;
	logic [CMP_W-1:0] lpt_x;
	phase_t     phase_n;

	assign lvl_l = item.left_button;
	assign lvl_r = item.right_button;
	assign lpt_x = CMP_W'(long_press_ticks);

	always_comb begin
		if (!lvl_l && !st.hist_l[0]) timer_l_n = '0;
		else if (lvl_l && timer_l != '1) timer_l_n = timer_l + 1'b1;
		else timer_l_n = timer_l;
		if (!lvl_r && !st.hist_r[0]) timer_r_n = '0;
		else if (lvl_r && timer_r != '1) timer_r_n = timer_r + 1'b1;
		else timer_r_n = timer_r;
	end

	assign short_l = (CMP_W'(timer_l_n) < lpt_x) && !lvl_l && st.hist_l[0];
	assign short_r = (CMP_W'(timer_r_n) < lpt_x) && !lvl_r && st.hist_r[0];
	assign long_r  = lvl_r && (CMP_W'(timer_r_n) > lpt_x);

	// phase transitions
	always_comb begin
		phase_n = st.phase;
		case (st.phase)
			PH_RUN: begin
				if (lvl_l && lvl_r) phase_n = PH_ENTER_WAIT;
			end
			PH_ENTER_WAIT: begin
				if (!lvl_l && !lvl_r) phase_n = PH_SETTING;
			end
			PH_SETTING: begin
				if (!short_r && !short_l && long_r) phase_n = PH_EXIT_WAIT;
			end
			PH_EXIT_WAIT: begin
				if (!lvl_l && !lvl_r) phase_n = PH_RUN;
			end
			default: phase_n = PH_RUN;
		endcase
	end

	// time, digit and history updates
	always_comb begin
		st_n = st;
		millis_n = millis;
		st_n.phase = phase_n;
		st_n.hist_l = {st.hist_l[0], lvl_l};
		st_n.hist_r = {st.hist_r[0], lvl_r};
		case (st.phase)
			PH_RUN: begin
				if (millis >= MS_LAST) begin
					millis_n = '0;
					if (st.second >= 6'd59) begin
						st_n.second = '0;
						if (st.minute >= 6'd59) begin
							st_n.minute = '0;
							st_n.hour = (st.hour >= 5'd23) ? 5'd0 : st.hour + 5'd1;
						end else begin
							st_n.minute = st.minute + 6'd1;
						end
					end else begin
						st_n.second = st.second + 6'd1;
					end
				end else begin
					millis_n = millis + 1'b1;
				end
				if (lvl_l && lvl_r) st_n.digit = '0;
			end
			PH_SETTING: begin
				if (short_r) begin
					st_n.digit = (st.digit >= 3'd5) ? 3'd0 : st.digit + 3'd1;
				end else if (short_l) begin
					case (st.digit)
						3'd0: st_n.hour = hour_tens_step(st.hour);
						3'd1: st_n.hour = hour_units_step(st.hour);
						3'd2: st_n.minute = tens_step(st.minute);
						3'd3: st_n.minute = units_step(st.minute);
						3'd4: st_n.second = tens_step(st.second);
						3'd5: st_n.second = units_step(st.second);
						default: st_n.hour = st.hour;
					endcase
				end
			end
			default: st_n.digit = st.digit;
		endcase
	end

	always_comb begin
		res.hours = st_n.hour;
		res.minutes = st_n.minute;
		res.seconds = st_n.second;
		res.setting_mode = (st_n.phase != PH_RUN);
		res.selected_digit = (st_n.phase != PH_RUN) ? st_n.digit : 3'd0;
	end

endmodule

// ===== sv/clock_24h_with_button_set.sv =====
// 24-hour clock advanced by one tick transaction, with two-button time setting.
// The result is registered: the core reads the input register and feeds the result register.
// Throughput: one transaction per cycle while out_stall is low; the clock state is
// updated as the input register hands its item to the result register.
// Reset: time 00:00:00, run mode, buttons released, threshold 1000 ticks.
// Top level; depends on ck24_pkg, ck24_core and ck24_cfg.
module clock_24h_with_button_set #(
	parameter int unsigned TICKS_PER_SECOND = 1000,
	parameter int unsigned PRESS_TIMER_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  ck24_pkg::ck24_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output ck24_pkg::ck24_out_t             out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ck24_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [ck24_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [ck24_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import ck24_pkg::*;

	localparam int unsigned MS_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

	logic                        valid_s1;
	ck24_in_t                    item_s1;
	logic                        valid_s2;
	ck24_out_t                   res_s2;
	logic                        adv, fire_s1;
	ck24_state_t                 st_q, st_n;
	logic [MS_W-1:0]             millis_q, millis_n;
	logic [PRESS_TIMER_BITS-1:0] timer_l_q, timer_r_q, timer_l_n, timer_r_n;
	logic [15:0]                 long_press_ticks;
	ck24_out_t                   res;

	assign adv      = !valid_s2 || !out_stall;
	assign fire_s1  = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	ck24_cfg u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.long_press_ticks (long_press_ticks)
	);

	ck24_core #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.PRESS_TIMER_BITS (PRESS_TIMER_BITS),
		.MS_W             (MS_W)
	) u_core (
		.item             (item_s1),
		.st               (st_q),
		.millis           (millis_q),
		.timer_l          (timer_l_q),
		.timer_r          (timer_r_q),
		.long_press_ticks (long_press_ticks),
		.st_n             (st_n),
		.millis_n         (millis_n),
		.timer_l_n        (timer_l_n),
		.timer_r_n        (timer_r_n),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
		if (fire_s1) res_s2 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{hour: '0, minute: '0, second: '0, phase: PH_RUN,
				digit: '0, hist_l: '0, hist_r: '0};
			millis_q  <= '0;
			timer_l_q <= '0;
			timer_r_q <= '0;
		end else if (fire_s1) begin
			st_q      <= st_n;
			millis_q  <= millis_n;
			timer_l_q <= timer_l_n;
			timer_r_q <= timer_r_n;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && out_stall) |-> in_stall)
		else $error("input not stalled while both stages are full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.setting_mode) |-> (res_s2.selected_digit == 3'd0))
		else $error("digit shown outside set mode");
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> (st_q == $past(st_q) && millis_q == $past(millis_q)))
		else $error("clock state changed without a transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_RUN) |-> (st_q.hour <= 5'd23 && st_q.minute <= 6'd59))
		else $error("time of day out of range");
`endif

endmodule

// ===== sim/clock_24h_with_button_set_tb.sv =====
`timescale 1ns / 1ps
// Testbench for clock_24h_with_button_set: streams millisecond tick transactions with random
// idling and output stalls, and checks every result against an in-bench clock model.
// Depends on ck24_pkg and the clock_24h_with_button_set RTL.
module clock_24h_with_button_set_tb;
	import ck24_pkg::*;

	localparam int unsigned TICKS_SEC = 1000;
	localparam logic [15:0] TIMER_MAX = 16'hFFFF;
	localparam int unsigned TIMEOUT_CYCLES = 500000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam logic [CFG_ADDR_W-1:0] ADDR_LONG_PRESS = CFG_ADDR_W'({REG_LONG_PRESS, 2'b00});

	localparam logic [2:0] DIG_HOUR_TENS = 3'd0;
	localparam logic [2:0] DIG_HOUR_UNITS = 3'd1;
	localparam logic [2:0] DIG_MIN_TENS = 3'd2;
	localparam logic [2:0] DIG_MIN_UNITS = 3'd3;
	localparam logic [2:0] DIG_SEC_TENS = 3'd4;
	localparam logic [2:0] DIG_SEC_UNITS = 3'd5;

	localparam int BTN_LEFT = 0;
	localparam int BTN_RIGHT = 1;

	// hist[b]: bit 1 previous level, bit 0 current level
	typedef struct packed {
		logic [15:0]      thr;
		logic [9:0]       msec;
		logic [5:0]       secs;
		logic [5:0]       mins;
		logic [4:0]       hrs;
		phase_t           phase;
		logic [2:0]       digit;
		logic [1:0][1:0]  hist;
		logic [1:0][15:0] timer;
	} clock_model_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ck24_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ck24_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	ck24_in_t tick_q[$];
	ck24_out_t time_exp_q[$];
	clock_model_t plan_st;
	clock_model_t check_st;
	int unsigned tick_count = 0;
	int unsigned err_count = 0;
	int unsigned tick_gap = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	bit no_idle = 1'b0;
	bit burst = 1'b0;

	clock_24h_with_button_set DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic clock_model_t clock_at_reset();
		clock_model_t s;
		s = '0;
		s.thr = LONG_PRESS_RESET;
		s.phase = PH_RUN;
		return s;
	endfunction

	function automatic void clock_tick(inout clock_model_t s, input ck24_in_t t,
			output ck24_out_t o);
		logic [1:0] lvl;
		logic sh_l, sh_r, lg_r;
		lvl = {t.right_button, t.left_button};
		if (s.phase == PH_RUN) begin
			s.msec = s.msec + 10'd1;
			if (s.msec >= TICKS_SEC) begin
				s.msec = '0;
				s.secs = s.secs + 6'd1;
				if (s.secs >= 6'd60) begin
					s.secs = '0;
					s.mins = s.mins + 6'd1;
					if (s.mins >= 6'd60) begin
						s.mins = '0;
						s.hrs = s.hrs + 5'd1;
						if (s.hrs >= 5'd24)
							s.hrs = '0;
					end
				end
			end
		end
		for (int b = 0; b < 2; b++) begin
			s.hist[b] = {s.hist[b][0], lvl[b]};
			if (s.hist[b] == 2'b00)
				s.timer[b] = '0;
			else if (lvl[b] && s.timer[b] != TIMER_MAX)
				s.timer[b] = s.timer[b] + 16'd1;
		end
		sh_l = (s.timer[BTN_LEFT] < s.thr) && (s.hist[BTN_LEFT] == 2'b10);
		sh_r = (s.timer[BTN_RIGHT] < s.thr) && (s.hist[BTN_RIGHT] == 2'b10);
		lg_r = s.hist[BTN_RIGHT][0] && (s.timer[BTN_RIGHT] > s.thr);
		case (s.phase)
		PH_RUN: begin
			if (s.hist[BTN_LEFT][0] && s.hist[BTN_RIGHT][0]) begin
				s.phase = PH_ENTER_WAIT;
				s.digit = DIG_HOUR_TENS;
			end
		end
		PH_ENTER_WAIT: begin
			if (!s.hist[BTN_LEFT][0] && !s.hist[BTN_RIGHT][0])
				s.phase = PH_SETTING;
		end
		PH_SETTING: begin
			if (sh_r) begin
				s.digit = (s.digit >= DIG_SEC_UNITS) ? DIG_HOUR_TENS : s.digit + 3'd1;
			end else if (sh_l) begin
				case (s.digit)
				DIG_HOUR_TENS: begin
					if (s.hrs >= 20) s.hrs = s.hrs - 5'd20;
					else if (s.hrs >= 10 && s.hrs % 10 >= 4) s.hrs = s.hrs - 5'd10;
					else s.hrs = s.hrs + 5'd10;
				end
				DIG_HOUR_UNITS: begin
					if (s.hrs == 23) s.hrs = 5'd20;
					else if (s.hrs >= 20) s.hrs = s.hrs + 5'd1;
					else if (s.hrs % 10 == 9) s.hrs = s.hrs - 5'd9;
					else s.hrs = s.hrs + 5'd1;
				end
				DIG_MIN_TENS: s.mins = (s.mins >= 50) ? s.mins - 6'd50 : s.mins + 6'd10;
				DIG_MIN_UNITS: s.mins = (s.mins % 10 == 9) ? s.mins - 6'd9 : s.mins + 6'd1;
				DIG_SEC_TENS: s.secs = (s.secs >= 50) ? s.secs - 6'd50 : s.secs + 6'd10;
				DIG_SEC_UNITS: s.secs = (s.secs % 10 == 9) ? s.secs - 6'd9 : s.secs + 6'd1;
				default: ;
				endcase
			end else if (lg_r) begin
				s.phase = PH_EXIT_WAIT;
			end
		end
		default: begin
			if (!s.hist[BTN_LEFT][0] && !s.hist[BTN_RIGHT][0])
				s.phase = PH_RUN;
		end
		endcase
		o.hours = s.hrs;
		o.minutes = s.mins;
		o.seconds = s.secs;
		o.setting_mode = (s.phase != PH_RUN);
		o.selected_digit = (s.phase != PH_RUN) ? s.digit : DIG_HOUR_TENS;
	endfunction

	function automatic int unsigned draw_wait();
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		if (no_idle || burst)
			return 0;
		return $urandom_range(0, 19);
	endfunction

	function automatic void log_result_error(string why, ck24_out_t e, ck24_out_t a);
		if (err_count < 10)
			$display("%s: expected %0d:%0d:%0d set=%0b digit=%0d, got %0d:%0d:%0d set=%0b digit=%0d",
				why, e.hours, e.minutes, e.seconds, e.setting_mode, e.selected_digit,
				a.hours, a.minutes, a.seconds, a.setting_mode, a.selected_digit);
		err_count++;
	endfunction

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tick_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (tick_gap != 0) begin
				in_valid <= 1'b0;
				tick_gap <= tick_gap - 1;
			end else if (tick_q.size() != 0) begin
				in_data <= tick_q.pop_front();
				in_valid <= 1'b1;
				tick_gap <= draw_wait();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and time prediction
	always @(posedge clk or negedge arst_n) begin
		ck24_out_t exp_t;
		int unsigned n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (time_exp_q.size() == 0) begin
					log_result_error("unexpected result", '0, out_data);
				end else begin
					exp_t = time_exp_q.pop_front();
					if (exp_t !== out_data)
						log_result_error("result mismatch", exp_t, out_data);
				end
				n = draw_wait();
				stall_left <= n;
				out_stall <= (n != 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= (stall_left > 1);
			end else begin
				out_stall <= 1'b0;
			end
			if (in_valid && !in_stall) begin
				clock_tick(check_st, in_data, exp_t);
				time_exp_q.push_back(exp_t);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == TIMEOUT_CYCLES) begin
			$display("clock_24h_with_button_set test failed");
			$finish;
		end
	end

	task automatic cfg_access(input logic wr, input logic [15:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_LONG_PRESS;
		pwdata <= {16'd0, data};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (!wr && prdata[15:0] !== data) begin
			if (err_count < 10)
				$display("threshold readback: expected %0d, got %0d", data, prdata[15:0]);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_threshold(input logic [15:0] v);
		cfg_access(1'b1, v);
		check_st.thr = v;
		plan_st.thr = v;
		cfg_access(1'b0, v);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (tick_q.size() != 0 || in_valid || time_exp_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_tick(input logic l, input logic r);
		ck24_in_t t;
		ck24_out_t unused;
		t.left_button = l;
		t.right_button = r;
		tick_q.push_back(t);
		clock_tick(plan_st, t, unused);
		tick_count++;
	endtask

	// len ticks held, then one release tick plus gap more
	task automatic add_press(input int b, input int unsigned len, input int unsigned gap);
		repeat (len) add_tick(b == BTN_LEFT, b == BTN_RIGHT);
		repeat (gap + 1) add_tick(1'b0, 1'b0);
	endtask

	function automatic int unsigned short_len();
		return (plan_st.thr > 1) ? $urandom_range(1, plan_st.thr - 1) : 1;
	endfunction

	function automatic int unsigned press_len();
		case ($urandom_range(0, 7))
		0: return plan_st.thr;
		1: return plan_st.thr + 1;
		default: return short_len();
		endcase
	endfunction

	task automatic enter_setting();
		repeat ($urandom_range(1, 3)) add_tick(1'b1, 1'b1);
		case ($urandom_range(0, 2))
		0: repeat ($urandom_range(1, 2)) add_tick(1'b1, 1'b0);
		1: repeat ($urandom_range(1, 2)) add_tick(1'b0, 1'b1);
		default: ;
		endcase
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
	endtask

	task automatic leave_setting();
		for (int k = 0; k < 4 && plan_st.phase != PH_RUN; k++) begin
			add_tick(1'b0, 1'b0);
			add_press(BTN_RIGHT, plan_st.thr + 1 + $urandom_range(0, 2), $urandom_range(1, 3));
		end
	endtask

	task automatic goto_digit(input logic [2:0] d);
		for (int k = 0; k < 8 && plan_st.digit != d; k++)
			add_press(BTN_RIGHT, short_len(), $urandom_range(1, 2));
	endtask

	task automatic step_selected();
		add_press(BTN_LEFT, short_len(), $urandom_range(1, 2));
	endtask

	// set 23:59:59 through the digit steps, then run a few ticks; needs thr >= 2
	task automatic set_day_end();
		leave_setting();
		enter_setting();
		goto_digit(DIG_HOUR_UNITS);
		for (int k = 0; k < 12 && plan_st.hrs % 10 != 3; k++) step_selected();
		goto_digit(DIG_HOUR_TENS);
		for (int k = 0; k < 4 && plan_st.hrs != 23; k++) step_selected();
		goto_digit(DIG_MIN_TENS);
		for (int k = 0; k < 8 && plan_st.mins < 50; k++) step_selected();
		goto_digit(DIG_MIN_UNITS);
		for (int k = 0; k < 12 && plan_st.mins % 10 != 9; k++) step_selected();
		goto_digit(DIG_SEC_TENS);
		for (int k = 0; k < 8 && plan_st.secs < 50; k++) step_selected();
		goto_digit(DIG_SEC_UNITS);
		for (int k = 0; k < 12 && plan_st.secs % 10 != 9; k++) step_selected();
		leave_setting();
		repeat ($urandom_range(1, 20)) add_tick(1'b0, 1'b0);
	endtask

	task automatic set_session();
		leave_setting();
		enter_setting();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 5))
			0, 1: add_press(BTN_RIGHT, press_len(), $urandom_range(0, 3));
			2, 3, 4: add_press(BTN_LEFT, press_len(), $urandom_range(0, 3));
			default: begin
				repeat (short_len()) add_tick(1'b1, 1'b1);
				add_tick(1'b0, 1'b0);
			end
			endcase
		end
		leave_setting();
		repeat ($urandom_range(0, 20))
			add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic gen_random(input int unsigned budget);
		int unsigned stop;
		stop = tick_count + budget;
		while (tick_count < stop) begin
			case ($urandom_range(0, 9))
			0, 1: repeat ($urandom_range(1, 10))
				add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			2: begin
				enter_setting();
				repeat ($urandom_range(1, 6))
					add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			default: set_session();
			endcase
		end
		leave_setting();
	endtask

	initial begin
		check_st = clock_at_reset();
		plan_st = clock_at_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, default threshold
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b0);
		add_tick(1'b0, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b1, 1'b1);
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
		add_press(BTN_RIGHT, 1, 0);
		add_press(BTN_LEFT, 1, 0);
		add_press(BTN_RIGHT, 1, 0);
		add_press(BTN_LEFT, 1, 0);
		// simultaneous short release: right wins
		add_tick(1'b1, 1'b1);
		add_tick(1'b0, 1'b0);
		add_tick(1'b0, 1'b0);
		wait_drained();

		set_threshold(16'($urandom_range(2, 4)));
		gen_random(60);
		set_day_end();
		wait_drained();

		// lowest threshold: no press is ever short
		set_threshold(16'd1);
		gen_random(30);
		wait_drained();

		set_threshold(16'($urandom_range(3, 8)));
		gen_random(50);
		wait_drained();

		// highest threshold: long holds still count as short presses
		set_threshold(16'hFFFF);
		no_idle = 1'b1;
		enter_setting();
		add_press(BTN_RIGHT, 1, 1);
		add_press(BTN_LEFT, 2, 1);
		add_press(BTN_RIGHT, 40, 1);
		add_press(BTN_LEFT, 3, 1);
		wait_drained();
		no_idle = 1'b0;

		set_threshold(16'd4);
		gen_random(40);
		wait_drained();

		if (err_count == 0 && time_exp_q.size() == 0)
			$display("clock_24h_with_button_set test passed");
		else
			$display("clock_24h_with_button_set test failed");
		$finish;
	end

endmodule
